@@ sv/csim_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity package
// Shared widths, constants and the accumulator bundle type.
// ----------------------------------------------------------------------------
package csim_pkg;

  localparam int ELEM_W           = 16;
  localparam int SIM_W            = 16;
  localparam int ACC_W            = 48;
  localparam int DEF_ELEMENT_BITS = 16;
  localparam int WIDE_W           = 128;
  localparam int MUL_STEPS        = 48;
  localparam int FIFO_DEPTH       = 2;

  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic [ACC_W-1:0]        a_energy;
    logic [ACC_W-1:0]        b_energy;
  } acc_bundle_t;

endpackage
`default_nettype wire

@@ sv/csim_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity channel interfaces
// Valid/ready channels for element pairs and for similarity results.
// ----------------------------------------------------------------------------
interface csim_in_if;
  import csim_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] a_elem;
  logic signed [ELEM_W-1:0] b_elem;
  logic                     last_pair;
  modport source (output valid, a_elem, b_elem, last_pair, input ready);
  modport sink (input valid, a_elem, b_elem, last_pair, output ready);
endinterface

interface csim_out_if;
  import csim_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SIM_W-1:0] similarity;
  logic                    zero_norm;
  modport source (output valid, similarity, zero_norm, input ready);
  modport sink (input valid, similarity, zero_norm, output ready);
endinterface
`default_nettype wire

@@ sv/csim_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity front end
// Multiplies each pair and accumulates the dot product and both energies.
// ----------------------------------------------------------------------------
module csim_front #(
  parameter int ELEMENT_BITS = csim_pkg::DEF_ELEMENT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  csim_in_if.sink                    in_ch,
  input  wire logic                  full,
  output logic                       push,
  output csim_pkg::acc_bundle_t      push_data
);
  import csim_pkg::*;

  localparam int PW    = 2 * ELEMENT_BITS;
  localparam int SUM_W = ((PW > ACC_W) ? PW : ACC_W) + 1;

  logic [31:0]                    a_raw, b_raw;
  logic signed [ELEMENT_BITS-1:0] a_e, b_e;
  logic signed [PW-1:0]           p_ab_r, p_aa_r, p_bb_r;
  logic                           v_r, last_r, go;
  logic [ACC_W-1:0]               dot_r, ea_r, eb_r;
  logic [ACC_W-1:0]               dot_nxt, ea_nxt, eb_nxt;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [PW-1:0] p);
    logic [SUM_W-1:0] s;
    s = {{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc} + {{(SUM_W-PW){p[PW-1]}}, p};
    if (!s[SUM_W-1] && (|s[SUM_W-2:ACC_W-1])) begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end else if (s[SUM_W-1] && !(&s[SUM_W-2:ACC_W-1])) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end
    return s[ACC_W-1:0];
  endfunction

  assign a_raw = {16'b0, in_ch.a_elem};
  assign b_raw = {16'b0, in_ch.b_elem};
  assign a_e   = a_raw[ELEMENT_BITS-1:0];
  assign b_e   = b_raw[ELEMENT_BITS-1:0];

  assign go          = !(v_r && last_r && full);
  assign in_ch.ready = !v_r || go;

  assign dot_nxt = sat_add(dot_r, p_ab_r);
  assign ea_nxt  = sat_add(ea_r, p_aa_r);
  assign eb_nxt  = sat_add(eb_r, p_bb_r);

  assign push               = v_r && last_r && go;
  assign push_data.dot      = dot_nxt;
  assign push_data.a_energy = ea_nxt;
  assign push_data.b_energy = eb_nxt;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      p_ab_r <= a_e * b_e;
      p_aa_r <= a_e * a_e;
      p_bb_r <= b_e * b_e;
      last_r <= in_ch.last_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      dot_r <= '0;
      ea_r  <= '0;
      eb_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        v_r <= in_ch.valid;
      end
      if (v_r && go) begin
        if (last_r) begin
          dot_r <= '0;
          ea_r  <= '0;
          eb_r  <= '0;
        end else begin
          dot_r <= dot_nxt;
          ea_r  <= ea_nxt;
          eb_r  <= eb_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/csim_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity sum queue
// Two-entry queue of finished accumulator bundles.
// ----------------------------------------------------------------------------
module csim_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire csim_pkg::acc_bundle_t push_data,
  output logic                       full,
  output logic                       not_empty,
  input  wire logic                  pop,
  output csim_pkg::acc_bundle_t      pop_data
);
  import csim_pkg::*;

  acc_bundle_t slot_r [FIFO_DEPTH];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;

  assign full      = cnt_r == 2'(FIFO_DEPTH);
  assign not_empty = cnt_r != 2'd0;
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ sv/csim_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity back end
// Binary search for the rounded cosine with a shared shift-add multiplier.
// ----------------------------------------------------------------------------
module csim_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  not_empty,
  output logic                       pop,
  input  wire csim_pkg::acc_bundle_t pop_data,
  csim_out_if.source                 out_ch
);
  import csim_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MD   = 3'd1;
  localparam logic [2:0] ST_MP   = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_MT   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]              state_r;
  logic                    neg_r, out_valid_r, zn_r;
  logic [ACC_W-1:0]        eb_r;
  logic [WIDE_W-1:0]       d2s_r, p_r, mc_r, acc_r, acc_nxt;
  logic [ACC_W-1:0]        mp_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [17:0]      lo_r, hi_r, mid_r, diff, mid;
  logic signed [18:0]      t;
  logic [16:0]             mag;
  logic [33:0]             mag2;
  logic signed [SIM_W-1:0] sim_r, res_r;
  logic [ACC_W-1:0]        dmag;
  logic                    mul_last, ge;

  assign acc_nxt  = mp_r[0] ? acc_r + mc_r : acc_r;
  assign mul_last = cnt_r == CNT_W'(MUL_STEPS - 1);
  assign diff     = hi_r - lo_r + 18'sd1;
  assign mid      = lo_r + (diff >>> 1);
  assign t        = {mid, 1'b0} - 19'sd1;
  assign mag      = t[18] ? 17'(-t) : t[16:0];
  assign mag2     = mag * mag;
  assign dmag     = pop_data.dot[ACC_W-1] ? -pop_data.dot : pop_data.dot;
  assign ge       = neg_r ? (d2s_r <= acc_nxt) : (d2s_r >= acc_nxt);
  assign pop      = state_r == ST_IDLE && not_empty;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.similarity = sim_r;
  assign out_ch.zero_norm  = zn_r;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (not_empty) begin
          neg_r <= pop_data.dot[ACC_W-1];
          eb_r  <= pop_data.b_energy;
          mc_r  <= WIDE_W'(dmag);
          mp_r  <= dmag;
          acc_r <= '0;
          cnt_r <= '0;
          p_r   <= WIDE_W'(pop_data.a_energy);
          res_r <= '0;
        end
      end
      ST_MD: begin
        acc_r <= acc_nxt;
        mc_r  <= mc_r << 1;
        mp_r  <= mp_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (mul_last) begin
          d2s_r <= {acc_nxt[95:0], 32'b0};
          mc_r  <= p_r;
          mp_r  <= eb_r;
          acc_r <= '0;
          cnt_r <= '0;
        end
      end
      ST_MP: begin
        acc_r <= acc_nxt;
        mc_r  <= mc_r << 1;
        mp_r  <= mp_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (mul_last) begin
          p_r  <= acc_nxt;
          lo_r <= -18'sd32768;
          hi_r <= 18'sd32767;
        end
      end
      ST_SRCH: begin
        mid_r <= mid;
        if (lo_r < hi_r) begin
          if (!neg_r && t <= 0) begin
            lo_r <= mid;
          end else if (neg_r && t >= 0) begin
            hi_r <= mid - 18'sd1;
          end else begin
            mc_r  <= p_r;
            mp_r  <= ACC_W'(mag2);
            acc_r <= '0;
            cnt_r <= '0;
          end
        end else begin
          res_r <= lo_r[SIM_W-1:0];
        end
      end
      ST_MT: begin
        acc_r <= acc_nxt;
        mc_r  <= mc_r << 1;
        mp_r  <= mp_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (mul_last) begin
          if (ge) begin
            lo_r <= mid_r;
          end else begin
            hi_r <= mid_r - 18'sd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (state_r == ST_FIN && (!out_valid_r || out_ch.ready)) begin
      sim_r <= res_r;
      zn_r  <= (p_r == '0) || (eb_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_FIN && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (not_empty) begin
            if (pop_data.a_energy == '0 || pop_data.b_energy == '0) begin
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_MD;
            end
          end
        end
        ST_MD: begin
          if (mul_last) begin
            state_r <= ST_MP;
          end
        end
        ST_MP: begin
          if (mul_last) begin
            state_r <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (lo_r >= hi_r) begin
            state_r <= ST_FIN;
          end else if (!(!neg_r && t <= 0) && !(neg_r && t >= 0)) begin
            state_r <= ST_MT;
          end
        end
        ST_MT: begin
          if (mul_last) begin
            state_r <= ST_SRCH;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  default disable iff (!rst_n);

  a_zero_norm_gives_zero: assert property (@(posedge clk)
    out_valid_r && zn_r |-> sim_r == '0)
    else $error("Zero norm result carries a nonzero similarity.");

  a_search_bounds: assert property (@(posedge clk)
    state_r == ST_MT |-> lo_r < hi_r && mid_r > lo_r && mid_r <= hi_r)
    else $error("Search midpoint is outside the live interval.");

  a_pop_only_idle: assert property (@(posedge clk)
    pop |=> state_r == ST_MD || state_r == ST_FIN)
    else $error("Popped bundle did not start a computation.");

endmodule
`default_nettype wire

@@ sv/cosine_similarity_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity core
// Streams element pairs of two vectors and returns their cosine in Q1.15.
//
// The in_pair channel takes one (a_elem, b_elem) pair per cycle, unless a
// last pair meets a full queue; last_pair marks the final pair of a vector.
// The front end accumulates the dot product and both energies as pairs are
// taken and pushes the sums into a two-entry queue, so streaming continues
// while earlier vectors finish. The back end evaluates each queued vector
// with one shift-add multiplier of 48 steps: the squared dot product, the
// energy product and up to sixteen search compares. That multiplier sets
// the per-vector rate; short vectors queue behind it. A zero energy gives a
// similarity of 0 with zero_norm set and skips the multiplier. Reset clears
// the accumulators, the queue and the output valid flag. When the receiver
// stalls, the result is held, the back end waits, and once the queue is
// full the input stalls at the next vector's last pair.
// ----------------------------------------------------------------------------
module cosine_similarity_core #(
  parameter int ELEMENT_BITS = csim_pkg::DEF_ELEMENT_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  csim_in_if.sink  in_pair,
  csim_out_if.source out_result
);
  import csim_pkg::*;

  acc_bundle_t push_data, pop_data;
  logic        push, pop, full, not_empty;

  csim_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_pair),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  csim_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  csim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_ch    (out_result)
  );

endmodule
`default_nettype wire
